FILE: rtl/core/wbc_pkg.sv
// shared constants, types and a helper function for the white blob centroid steering block
package wbc_pkg;

    // pixel, accumulator, config index and divide step widths
    localparam int PIX_W   = 8;
    localparam int WIDTH_W = 13;
    localparam int COL_W   = 12;
    localparam int COUNT_W = 25;
    localparam int SUM_W   = 36;
    localparam int MEAN_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam logic [PIX_W-1:0]   WHITE_LEVEL = '1;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX     = '1;
    localparam logic [MEAN_W-1:0]  MEAN_MAX    = '1;

    // reciprocal of three: x/3 == (x * RECIP_THIRD) >> RECIP_SHIFT for x below 2^14
    localparam int RECIP_THIRD = 10923;
    localparam int RECIP_SHIFT = 15;
    localparam int PROD_W      = 28;

    // reset values of the configuration registers
    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd640;
    localparam logic [COUNT_W-1:0] RST_MIN_COUNT   = 25'd10;
    localparam logic [COUNT_W-1:0] RST_MAX_COUNT   = 25'd50000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT   = 2'd2;

    // steering commands
    localparam logic [1:0] CMD_STOP    = 2'd0;
    localparam logic [1:0] CMD_LEFT    = 2'd1;
    localparam logic [1:0] CMD_RIGHT   = 2'd2;
    localparam logic [1:0] CMD_FORWARD = 2'd3;

    // queue between accumulation and decision
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // totals of one frame
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } t_frame_stats;

    // decision thresholds
    typedef struct packed {
        logic [WIDTH_W-1:0] left_bound;
        logic [WIDTH_W-1:0] right_bound;
        logic [COUNT_W-1:0] min_count;
        logic [COUNT_W-1:0] max_count;
    } t_limits;

    // width clamped to 1..MAX_WIDTH
    function automatic logic [WIDTH_W-1:0] f_eff_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w == '0) begin
            r = WIDTH_W'(1);
        end else if (w > MAX_WIDTH) begin
            r = MAX_WIDTH;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/wbc_front.sv
// pixel front end: column tracking, white pixel count and column sum per frame
module wbc_front import wbc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [PIX_W-1:0]    i_red,
    input  logic [PIX_W-1:0]    i_green,
    input  logic [PIX_W-1:0]    i_blue,
    input  logic                i_frame_end,
    input  logic [WIDTH_W-1:0]  i_eff_width,
    input  logic                i_queue_full,
    output logic                o_push,
    output t_frame_stats        o_stats
);

    logic [COL_W-1:0]   r_col,   n_col;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0]   r_sum,   n_sum;

    logic               accept;
    logic               white;
    logic [COL_W-1:0]   col;
    logic [WIDTH_W-1:0] col_inc;
    logic [SUM_W:0]     sum_add;
    logic [COUNT_W-1:0] count_upd;
    logic [SUM_W-1:0]   sum_upd;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign white      = (i_red == WHITE_LEVEL) && (i_green == WHITE_LEVEL)
                        && (i_blue == WHITE_LEVEL);

    // column of this pixel, forced back into range after a width change
    always_comb begin
        col = ({1'b0, r_col} >= i_eff_width) ? '0 : r_col;
        col_inc = {1'b0, col} + WIDTH_W'(1);
    end

    // saturating accumulation
    always_comb begin
        sum_add   = {1'b0, r_sum} + (SUM_W+1)'(col);
        count_upd = r_count;
        sum_upd   = r_sum;
        if (white) begin
            if (r_count != COUNT_MAX) begin
                count_upd = r_count + COUNT_W'(1);
            end
            sum_upd = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        end
    end

    assign o_push        = accept && i_frame_end;
    assign o_stats.sum   = sum_upd;
    assign o_stats.count = count_upd;

    // next state, frame end resets the column and the totals (count to one, sum to zero)
    always_comb begin
        n_col   = r_col;
        n_count = r_count;
        n_sum   = r_sum;
        if (accept) begin
            if (i_frame_end) begin
                n_col   = '0;
                n_count = COUNT_W'(1);
                n_sum   = '0;
            end else begin
                n_col   = (col_inc >= i_eff_width) ? '0 : col_inc[COL_W-1:0];
                n_count = count_upd;
                n_sum   = sum_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_count <= COUNT_W'(1);
            r_sum   <= '0;
        end else begin
            r_col   <= n_col;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

FILE: rtl/core/wbc_queue.sv
// short fifo of frame totals between the front end and the divider
module wbc_queue import wbc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_frame_stats i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output t_frame_stats o_data
);

    t_frame_stats        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QFILL_W-1:0]  r_fill,   n_fill;
    logic                do_pop;

    assign o_full  = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !do_pop) begin
            n_fill = r_fill + QFILL_W'(1);
        end else if (!i_push && do_pop) begin
            n_fill = r_fill - QFILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/wbc_back.sv
// back end: bit-serial mean divide, steering decision and output register
module wbc_back import wbc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_frame_stats        i_q_data,
    output logic                o_q_pop,
    input  t_limits             i_limits,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_command,
    output logic [MEAN_W-1:0]   o_mean_column,
    output logic [COUNT_W-1:0]  o_white_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [STEP_W-1:0]   r_step,  n_step;
    logic [SUM_W-1:0]    r_quo,   n_quo;
    logic [COUNT_W:0]    r_rem,   n_rem;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_cmd,   n_cmd;
    logic [MEAN_W-1:0]   r_mean,  n_mean;
    logic [COUNT_W-1:0]  r_wcnt,  n_wcnt;

    logic [COUNT_W:0]    rem_sh;
    logic                q_bit;
    logic [MEAN_W-1:0]   mean;
    logic [1:0]          cmd;
    logic                out_free;

    // one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem[COUNT_W-1:0], r_quo[SUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_count});
    end

    // saturated mean and steering decision
    always_comb begin
        mean = (|r_quo[SUM_W-1:MEAN_W]) ? MEAN_MAX : r_quo[MEAN_W-1:0];
        if ((mean != '0) && ({1'b0, mean} < i_limits.left_bound)) begin
            cmd = CMD_LEFT;
        end else if ({1'b0, mean} > i_limits.right_bound) begin
            cmd = CMD_RIGHT;
        end else begin
            cmd = CMD_FORWARD;
        end
        if ((r_count < i_limits.min_count) || (r_count > i_limits.max_count)) begin
            cmd = CMD_STOP;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_mean      = r_mean;
        n_wcnt      = r_wcnt;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_quo   = i_q_data.sum;
                    n_count = i_q_data.count;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = q_bit ? (rem_sh - {1'b0, r_count}) : rem_sh;
                n_quo  = {r_quo[SUM_W-2:0], q_bit};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_cmd       = cmd;
                    n_mean      = mean;
                    n_wcnt      = r_count;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_count <= n_count;
        r_cmd   <= n_cmd;
        r_mean  <= n_mean;
        r_wcnt  <= n_wcnt;
    end

    assign o_out_valid   = r_out_valid;
    assign o_command     = r_cmd;
    assign o_mean_column = r_mean;
    assign o_white_count = r_wcnt;

endmodule

FILE: rtl/core/white_blob_centroid_steer.sv
// top level: config registers, pixel front end, totals queue and divide/decide back end
// throughput: one pixel per cycle; the input stalls only when two frame totals are queued
// result path: queue, bit-serial restoring divide, done state, then the output register
// the back end pops new totals only once idle again; short frames fill the 2-entry queue
// reset: synchronous active low; width 640, limits 10 and 50000, column 0, count 1, sum 0
// no clearing pass: the block takes pixels in the first cycle after reset
module white_blob_centroid_steer import wbc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_red,
    input  logic [PIX_W-1:0]     i_green,
    input  logic [PIX_W-1:0]     i_blue,
    input  logic                 i_frame_end,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_command,
    output logic [MEAN_W-1:0]    o_mean_column,
    output logic [COUNT_W-1:0]   o_white_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COUNT_W-1:0]   i_cfg_data
);

    logic [WIDTH_W-1:0] r_image_width;
    logic [COUNT_W-1:0] r_min_count;
    logic [COUNT_W-1:0] r_max_count;
    logic [WIDTH_W-1:0] r_left_bound;
    logic [WIDTH_W-1:0] r_right_bound;

    logic [WIDTH_W-1:0] eff_width;
    logic [PROD_W-1:0]  left_prod;
    logic [PROD_W-1:0]  right_prod;
    t_limits            limits;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    t_frame_stats       q_in;
    t_frame_stats       q_out;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= RST_IMAGE_WIDTH;
            r_min_count   <= RST_MIN_COUNT;
            r_max_count   <= RST_MAX_COUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_MIN_COUNT:   r_min_count   <= i_cfg_data;
                CFG_MAX_COUNT:   r_max_count   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zone bounds w/3 and 2w/3 by reciprocal multiply, registered
    assign eff_width  = f_eff_width(r_image_width);
    assign left_prod  = PROD_W'(eff_width) * PROD_W'(RECIP_THIRD);
    assign right_prod = PROD_W'({eff_width, 1'b0}) * PROD_W'(RECIP_THIRD);

    always_ff @(posedge i_clk) begin
        r_left_bound  <= WIDTH_W'(left_prod >> RECIP_SHIFT);
        r_right_bound <= WIDTH_W'(right_prod >> RECIP_SHIFT);
    end

    assign limits.left_bound  = r_left_bound;
    assign limits.right_bound = r_right_bound;
    assign limits.min_count   = r_min_count;
    assign limits.max_count   = r_max_count;

    wbc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_frame_end  (i_frame_end),
        .i_eff_width  (eff_width),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_stats      (q_in)
    );

    wbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    wbc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .i_limits      (limits),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_command     (o_command),
        .o_mean_column (o_mean_column),
        .o_white_count (o_white_count)
    );

    // no frame totals pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("frame totals pushed into full queue");

    // stop exactly when the count is outside the limits
    a_stop_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_command == CMD_STOP) ==
            ((o_white_count < r_min_count) || (o_white_count > r_max_count))))
        else $error("stop command does not match count limits");

    // left turn needs a nonzero mean
    a_left_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_command == CMD_LEFT)) |-> (o_mean_column != '0))
        else $error("left command with zero mean column");

    // count always includes the initial one
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_white_count != '0))
        else $error("zero white count on result");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the white blob centroid steering block
module testbench import wbc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // index past the register list
    localparam int SETTLE_CYCLES = 48;                  // result latency plus margin
    localparam int HOLD_CYCLES   = 300;                 // long receiver hold-off

    // one steering decision as the block reports it
    typedef struct packed {
        logic [1:0]         command;
        logic [MEAN_W-1:0]  mean_column;
        logic [COUNT_W-1:0] white_count;
    } t_steer_decision;

    // tracks column, white count and column sum; predicts each frame's decision
    class centroid_checker;
        logic [WIDTH_W-1:0] width_reg;
        logic [COUNT_W-1:0] min_reg;
        logic [COUNT_W-1:0] max_reg;
        int unsigned        col_pos;
        logic [COUNT_W-1:0] white_cnt;
        logic [SUM_W-1:0]   col_sum;
        t_steer_decision    decisions_due[$];
        int                 mismatches;
        int                 pixels_seen;
        int                 decisions_checked;
        int                 cmd_seen[4];

        function new();
            width_reg = RST_IMAGE_WIDTH;
            min_reg = RST_MIN_COUNT;
            max_reg = RST_MAX_COUNT;
            clear_frame();
            mismatches = 0;
            pixels_seen = 0;
            decisions_checked = 0;
            cmd_seen = '{default: 0};
        endfunction

        function void clear_frame();
            col_pos = 0;
            white_cnt = COUNT_W'(1);
            col_sum = '0;
        endfunction

        // row length actually used: zero acts as one, large values clamp
        function int unsigned span();
            int unsigned w;
            w = width_reg;
            if (w == 0) begin
                w = 1;
            end else if (w > MAX_WIDTH) begin
                w = MAX_WIDTH;
            end
            return w;
        endfunction

        // column the next pixel lands in, pulled back if the width shrank mid-row
        function int unsigned cur_col();
            return (col_pos >= span()) ? 0 : col_pos;
        endfunction

        function int pending();
            return decisions_due.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH: width_reg = data[WIDTH_W-1:0];
                CFG_MIN_COUNT:   min_reg = data;
                CFG_MAX_COUNT:   max_reg = data;
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                 logic [PIX_W-1:0] b, logic last);
            int unsigned     w;
            int unsigned     c;
            int unsigned     m;
            logic [SUM_W-1:0] quot;
            t_steer_decision d;
            w = span();
            c = cur_col();
            pixels_seen++;
            // white pixels count and add their column, both saturating
            if (r == WHITE_LEVEL && g == WHITE_LEVEL && b == WHITE_LEVEL) begin
                if (white_cnt != COUNT_MAX) white_cnt++;
                col_sum = (col_sum > SUM_MAX - c) ? SUM_MAX : col_sum + c;
            end
            col_pos = (c + 1 >= w) ? 0 : c + 1;
            if (!last) return;
            // frame done: mean column, zone decision, count limits override
            quot = col_sum / white_cnt;
            m = (quot > MEAN_MAX) ? MEAN_MAX : quot[MEAN_W-1:0];
            if (m > 0 && m < w / 3) begin
                d.command = CMD_LEFT;
            end else if (m > (w * 2) / 3) begin
                d.command = CMD_RIGHT;
            end else begin
                d.command = CMD_FORWARD;
            end
            if (white_cnt < min_reg || white_cnt > max_reg) d.command = CMD_STOP;
            d.mean_column = MEAN_W'(m);
            d.white_count = white_cnt;
            decisions_due.push_back(d);
            clear_frame();
        endfunction

        function void check_decision(logic [1:0] cmd, logic [MEAN_W-1:0] mean,
                                     logic [COUNT_W-1:0] cnt);
            t_steer_decision want;
            if (decisions_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected decision: cmd %0d mean %0d count %0d",
                             cmd, mean, cnt);
                mismatches++;
                return;
            end
            want = decisions_due.pop_front();
            decisions_checked++;
            cmd_seen[want.command]++;
            if (cmd !== want.command || mean !== want.mean_column ||
                cnt !== want.white_count) begin
                if (mismatches < 10)
                    $display({"decision %0d: expected cmd %0d mean %0d count %0d, ",
                              "got cmd %0d mean %0d count %0d"},
                             decisions_checked, want.command, want.mean_column,
                             want.white_count, cmd, mean, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_red;
    logic [PIX_W-1:0]     i_green;
    logic [PIX_W-1:0]     i_blue;
    logic                 i_frame_end;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_command;
    logic [MEAN_W-1:0]    o_mean_column;
    logic [COUNT_W-1:0]   o_white_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COUNT_W-1:0]   i_cfg_data;

    centroid_checker board = new();

    int  snd_idle_pct = 34;
    int  rcv_idle_pct = 70;
    int  snd_burst = 0;
    int  hold_seq = 0;
    int  settings_used = 0;

    white_blob_centroid_steer uut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, quiet bursts, and one long hold-off on request
    initial begin
        int hold_left;
        int rcv_burst;
        int hold_seen;
        hold_left = 0;
        rcv_burst = 0;
        hold_seen = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_left = HOLD_CYCLES;
                hold_seen = hold_seq;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rcv_burst > 0) begin
                rcv_burst--;
                i_out_stall <= 1'b0;
            end else if ($urandom_range(49) == 0) begin
                rcv_burst = $urandom_range(40, 10);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    // check every accepted result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_decision(o_command, o_mean_column, o_white_count);
    end

    // offer one pixel, with random idle cycles ahead of it, until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic last);
        if (snd_burst > 0) begin
            snd_burst--;
        end else if ($urandom_range(29) == 0) begin
            snd_burst = $urandom_range(40, 10);
        end
        while (snd_burst == 0 && $urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        i_frame_end <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_pixel(r, g, b, last);
    endtask

    // one frame with whites clustered in columns lo..hi, sparse noise elsewhere
    task automatic send_frame(input int len, input int lo, input int hi);
        int unsigned      c;
        int               pick;
        bit               white;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            c = board.cur_col();
            white = $urandom_range(99) < ((c >= lo && c <= hi) ? 80 : 8);
            pick = $urandom_range(3);
            r = PIX_W'($urandom);
            g = PIX_W'($urandom);
            b = PIX_W'($urandom);
            if (white) begin
                r = WHITE_LEVEL;
                g = WHITE_LEVEL;
                b = WHITE_LEVEL;
            end else if (pick == 0) begin
                // near white: only blue is random
                r = WHITE_LEVEL;
                g = WHITE_LEVEL;
            end else if (pick == 1) begin
                r = '0;
                g = '0;
                b = '0;
            end
            send_pixel(r, g, b, i == len - 1);
        end
    endtask

    // random frames, mostly short, some spanning several rows
    task automatic run_frames(input int n_pix);
        int sent;
        int len;
        int span_cols;
        int lo;
        sent = 0;
        while (sent < n_pix) begin
            span_cols = (board.span() < 64) ? board.span() : 64;
            lo = $urandom_range(span_cols - 1);
            if ($urandom_range(7) == 0) begin
                len = $urandom_range(300, 24);
            end else begin
                len = $urandom_range(24, 1);
            end
            if (len > n_pix - sent) begin
                len = n_pix - sent;
            end
            send_frame(len, lo, lo + $urandom_range(3));
            sent += len;
        end
    endtask

    // drive one register transaction; valid stays high for the next one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_register(idx, data);
    endtask

    task automatic program_registers(input logic [COUNT_W-1:0] width_val,
                                     input logic [COUNT_W-1:0] min_val,
                                     input logic [COUNT_W-1:0] max_val);
        // the spare index must leave every register alone
        cfg_write(CFG_SPARE, 25'h1);
        cfg_write(CFG_IMAGE_WIDTH, width_val);
        cfg_write(CFG_MIN_COUNT, min_val);
        cfg_write(CFG_MAX_COUNT, max_val);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // drop valid, let all decisions come out, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] width_val,
                             input logic [COUNT_W-1:0] min_val,
                             input logic [COUNT_W-1:0] max_val,
                             input int snd_pct, input int rcv_pct, input int n_pix);
        wait_idle();
        program_registers(width_val, min_val, max_val);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        run_frames(n_pix);
    endtask

    // main sequence
    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_red <= '0;
        i_green <= '0;
        i_blue <= '0;
        i_frame_end <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: tiny frames fall below the minimum count
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'hfe, 8'hff, 8'hff, 1'b0);
        send_pixel(8'hff, 8'hfe, 8'hff, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hfe, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b1);

        // narrow rows, open limits: zero mean, left zone, mean on the left bound
        wait_idle();
        program_registers(25'd9, 25'd0, COUNT_MAX);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
        send_pixel(8'h80, 8'h40, 8'h01, 1'b0);
        send_pixel(8'h7f, 8'hff, 8'hff, 1'b0);
        send_pixel(8'hff, 8'h00, 8'hff, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
        send_pixel(8'hfe, 8'hfe, 8'hfe, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b1);

        // sender idles lightly, receiver heavily
        run_phase(25'h1ffe00c, 25'd2, 25'd40, 34, 70, 125);
        run_phase(25'd0, 25'd0, COUNT_MAX, 34, 70, 125);

        // roles swapped; a partial row is left open across the width change
        run_phase(25'd8191, 25'd1, 25'd60, 70, 34, 125);
        for (int i = 0; i < 10; i++) begin
            send_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, 1'b0);
        end
        run_phase(25'd7, 25'h1000001, 25'd0, 70, 34, 125);

        // no idling on either side
        run_phase(25'd4096, 25'd0, COUNT_MAX, 0, 0, 125);
        run_phase(25'd20, 25'd3, 25'd25, 0, 0, 125);

        // receiver holds off while short frames keep coming, filling the block
        wait_idle();
        program_registers(25'd5, 25'd0, COUNT_MAX);
        hold_seq++;
        for (int i = 0; i < 40; i++) begin
            send_frame($urandom_range(3, 1), 0, 4);
        end

        wait_idle();
        $display("covered %0d pixels and %0d steering decisions over %0d register settings",
                 board.pixels_seen, board.decisions_checked, settings_used);
        $display("decisions: stop %0d, left %0d, right %0d, forward %0d; mismatches %0d",
                 board.cmd_seen[CMD_STOP], board.cmd_seen[CMD_LEFT],
                 board.cmd_seen[CMD_RIGHT], board.cmd_seen[CMD_FORWARD],
                 board.mismatches);
        if (board.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: white_blob_centroid_steer.f
rtl/core/wbc_pkg.sv
rtl/core/wbc_front.sv
rtl/core/wbc_queue.sv
rtl/core/wbc_back.sv
rtl/core/white_blob_centroid_steer.sv
tb/testbench.sv
